>>> rtl/hrfl_pkg.sv
// hrfl_pkg: shared types and constants for the hex record flash loader
// used by hrfl_if.sv, hrfl_field.sv and hex_record_flash_loader.sv
`default_nettype none

package hrfl_pkg;

  localparam int CharW      = 8;
  localparam int ValW       = 31;
  localparam int AddrW      = 32;
  localparam int WinW       = 24;
  localparam int CfgIdxW    = 1;
  localparam int CntW       = 3;
  localparam int WordsW     = 16;
  localparam int FieldChars = 8;

  localparam logic [CharW-1:0] CharColon = 8'h3A;
  localparam logic [ValW-1:0]  SatMax    = 31'h7FFF_FFFF;
  localparam logic [AddrW-1:0] AddrStep  = 32'd4;
  localparam logic [CntW-1:0]  CntLast   = CntW'(FieldChars - 1);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIN_START = 1'b0,
    CFG_WIN_END   = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    CMD_ERASE = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_t;

  // control from the record sequencer to the field accumulator
  typedef struct packed {
    logic take;
    logic clear;
  } fld_ctrl_t;

endpackage : hrfl_pkg

`default_nettype wire

>>> rtl/hrfl_if.sv
// hrfl_if: valid/ready channels for characters in and flash commands out
// depends on hrfl_pkg
`default_nettype none

interface hrfl_char_if
  import hrfl_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface : hrfl_char_if

interface hrfl_cmd_if
  import hrfl_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             command;
  logic [AddrW-1:0] flash_address;
  logic [ValW-1:0]  word_first;
  logic [ValW-1:0]  word_second;
  logic             record_end;

  modport source (output valid, output command, output flash_address, output word_first,
                  output word_second, output record_end, input ready);
  modport sink   (input valid, input command, input flash_address, input word_first,
                  input word_second, input record_end, output ready);
endinterface : hrfl_cmd_if

`default_nettype wire

>>> rtl/hrfl_field.sv
// hrfl_field: saturating hex field accumulator, stops at the first non-hex character
// depends on hrfl_pkg
`default_nettype none

module hrfl_field
  import hrfl_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  fld_ctrl_t        ctrl,
  input  logic [CharW-1:0] char_code,
  output logic [ValW-1:0]  value_next
);

  logic [ValW-1:0] value;
  logic            stopped;
  logic            stopped_next;
  logic            is_hex;
  logic [3:0]      digit;

  always_comb begin
    is_hex = 1'b1;
    digit  = 4'd0;
    priority if (char_code >= "0" && char_code <= "9") begin
      digit = 4'(char_code - "0");
    end else if (char_code >= "a" && char_code <= "f") begin
      digit = 4'(char_code - "a" + 8'd10);
    end else if (char_code >= "A" && char_code <= "F") begin
      digit = 4'(char_code - "A" + 8'd10);
    end else begin
      is_hex = 1'b0;
    end
  end

  always_comb begin
    value_next   = value;
    stopped_next = stopped;
    if (ctrl.take && !stopped) begin
      if (is_hex) begin
        // any of the top nibble bits set means the shift passes the limit
        value_next = (|value[ValW-1:ValW-4]) ? SatMax : {value[ValW-5:0], digit};
      end else begin
        stopped_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      value   <= '0;
      stopped <= 1'b0;
    end else begin
      value   <= value_next;
      stopped <= stopped_next;
    end
  end

endmodule : hrfl_field

`default_nettype wire

>>> rtl/hex_record_flash_loader.sv
// Hex record flash loader. Takes one ASCII character per request and parses
// ':' + 8 hex chars of block address + 8 hex chars of word count + 8-char data
// words; emits a page erase when the count field completes and the address is
// inside [win_start, win_end), and a double-word write for every
// second data word, flagging record end on the last one. One character is taken
// every cycle: the parse step and the command register sit in a single pass,
// so ready only drops while a command waits in the output register unaccepted.
// depends on hrfl_pkg, hrfl_if, hrfl_field
`default_nettype none

module hex_record_flash_loader
  import hrfl_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [WinW-1:0]    cfg_data,
  hrfl_char_if.sink          char_in,
  hrfl_cmd_if.source         cmd_out
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ADDR  = 4'b0010,
    ST_COUNT = 4'b0100,
    ST_DATA  = 4'b1000
  } state_t;

  state_t            state, state_next;
  logic [CntW-1:0]   cnt, cnt_next;
  logic [WinW-1:0]   win_start, win_end;
  logic [ValW-1:0]   block_address, block_address_next;
  logic [ValW-1:0]   word_target, word_target_next;
  logic [ValW-1:0]   held_word, held_word_next;
  logic              expect_first_word, expect_first_word_next;
  logic [WordsW-1:0] words_done, words_done_next;
  logic [AddrW-1:0]  write_address, write_address_next;

  logic              accept;
  logic              last_char;
  logic              emit;
  logic              emit_done;
  cmd_t              emit_cmd;
  logic [AddrW-1:0]  emit_addr;
  logic [ValW-1:0]   emit_w1, emit_w2;
  logic [WordsW-1:0] words_inc;
  fld_ctrl_t         fctrl;
  logic [ValW-1:0]   fv_next;

  assign char_in.ready = !cmd_out.valid || cmd_out.ready;
  assign accept        = char_in.valid && char_in.ready;
  assign last_char     = (cnt == CntLast);
  assign words_inc     = words_done + WordsW'(1);

  hrfl_field u_field (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (fctrl),
    .char_code  (char_in.char_code),
    .value_next (fv_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      win_start <= '0;
      win_end   <= '1;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_WIN_START: win_start <= cfg_data;
        CFG_WIN_END:   win_end   <= cfg_data;
        default:       ;
      endcase
    end
  end

  always_comb begin
    state_next             = state;
    cnt_next               = cnt;
    block_address_next     = block_address;
    word_target_next       = word_target;
    held_word_next         = held_word;
    expect_first_word_next = expect_first_word;
    words_done_next        = words_done;
    write_address_next     = write_address;
    fctrl                  = '0;
    emit                   = 1'b0;
    emit_done              = 1'b0;
    emit_cmd               = CMD_ERASE;
    emit_addr              = '0;
    emit_w1                = '0;
    emit_w2                = '0;
    if (accept) begin
      fctrl.take = (state != ST_IDLE);
      cnt_next   = (state == ST_IDLE) ? '0 : cnt + CntW'(1);
      unique case (state)
        ST_IDLE: begin
          if (char_in.char_code == CharColon) begin
            fctrl.clear = 1'b1;
            state_next  = ST_ADDR;
          end
        end
        ST_ADDR: begin
          if (last_char) begin
            block_address_next = fv_next;
            fctrl.clear        = 1'b1;
            state_next         = ST_COUNT;
          end
        end
        ST_COUNT: begin
          if (last_char) begin
            word_target_next       = fv_next;
            expect_first_word_next = 1'b1;
            words_done_next        = '0;
            write_address_next     = {1'b0, block_address};
            fctrl.clear            = 1'b1;
            state_next             = ST_DATA;
            emit      = (block_address >= ValW'(win_start)) &&
                        (block_address < ValW'(win_end));
            emit_cmd  = CMD_ERASE;
            emit_addr = {1'b0, block_address};
          end
        end
        ST_DATA: begin
          if (last_char) begin
            words_done_next = words_inc;
            fctrl.clear     = 1'b1;
            if (expect_first_word) begin
              held_word_next         = fv_next;
              expect_first_word_next = 1'b0;
            end else begin
              emit_done              = !(ValW'(words_inc) < word_target);
              expect_first_word_next = 1'b1;
              emit                   = 1'b1;
              emit_cmd               = CMD_WRITE;
              emit_addr              = write_address;
              emit_w1                = held_word;
              emit_w2                = fv_next;
              write_address_next     = write_address + AddrStep;
              state_next             = emit_done ? ST_IDLE : ST_DATA;
            end
          end
        end
        default: state_next = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      cnt               <= '0;
      block_address     <= '0;
      word_target       <= '0;
      held_word         <= '0;
      expect_first_word <= 1'b1;
      words_done        <= '0;
      write_address     <= '0;
    end else begin
      state             <= state_next;
      cnt               <= cnt_next;
      block_address     <= block_address_next;
      word_target       <= word_target_next;
      held_word         <= held_word_next;
      expect_first_word <= expect_first_word_next;
      words_done        <= words_done_next;
      write_address     <= write_address_next;
    end
  end

  // command output register
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_out.valid <= 1'b0;
    end else if (emit) begin
      cmd_out.valid <= 1'b1;
    end else if (cmd_out.ready) begin
      cmd_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      cmd_out.command       <= emit_cmd;
      cmd_out.flash_address <= emit_addr;
      cmd_out.word_first    <= emit_w1;
      cmd_out.word_second   <= emit_w2;
      cmd_out.record_end    <= emit_done;
    end
  end

`ifndef SYNTHESIS
  a_idle_cnt_zero: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> cnt == '0)
    else $error("char counter not zero while waiting for colon");

  a_expect_outside_data: assert property (@(posedge clk) disable iff (rst)
    state != ST_DATA |-> expect_first_word)
    else $error("pair half-filled outside the data phase");

  a_end_returns_idle: assert property (@(posedge clk) disable iff (rst)
    emit && emit_done |=> state == ST_IDLE && cmd_out.valid && cmd_out.record_end)
    else $error("record end did not return to idle");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cmd_out.valid && !cmd_out.ready |-> !char_in.ready)
    else $error("request taken while command is stalled");
`endif

endmodule : hex_record_flash_loader

`default_nettype wire
